[hw/rtl/csl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types, token codes, character classes and the keyword table of the
// C subset lexer.
// ----------------------------------------------------------------------------
package csl_pkg;

	localparam int POS_BITS_DEF  = 16;
	localparam int LEN_BITS_DEF  = 16;
	localparam int KW_CHARS      = 8;
	localparam int KW_PREFIX_W   = 8 * KW_CHARS;
	localparam int KW_IDX_W      = $clog2(KW_CHARS);
	localparam int KW_COUNT      = 11;
	localparam int KW_LEN_W      = 4;

	typedef enum logic [4:0] {
		S_BEGIN, S_IDENT, S_INT, S_FLOAT, S_ASSIGN, S_LESS, S_GTR, S_NOTEQ,
		S_ZERO, S_OCT, S_HEXPRE, S_HEX, S_STR, S_AND, S_OR, S_SQ, S_CHAR,
		S_CHARERR
	} lex_state_t;

	typedef enum logic [4:0] {
		TOK_ERR, TOK_ID, TOK_STR, TOK_CHR, TOK_INT, TOK_LONG, TOK_FLT, TOK_KW,
		TOK_PL, TOK_MINUS, TOK_MUL, TOK_DIV, TOK_LS, TOK_LSEQ, TOK_EQ, TOK_GTEQ,
		TOK_GT, TOK_NTEQ, TOK_AND, TOK_OR, TOK_ASSIGN, TOK_LPAR, TOK_RPAR,
		TOK_LBRACE, TOK_RBRACE, TOK_SEMI, TOK_COMMA, TOK_LBRK, TOK_RBRK,
		TOK_SHARP
	} tok_type_t;

	// Keyword text packed first character in the low byte.
	localparam logic [KW_PREFIX_W-1:0] KW_TEXT [KW_COUNT] = '{
		64'h0000_0000_0000_6669,  // if
		64'h0000_0000_6573_6c65,  // else
		64'h0000_0065_6c69_6877,  // while
		64'h0000_0000_0072_6f66,  // for
		64'h0000_6e72_7574_6572,  // return
		64'h0000_006b_6165_7262,  // break
		64'h6575_6e69_746e_6f63,  // continue
		64'h0000_0000_7261_6863,  // char
		64'h0000_0000_0074_6e69,  // int
		64'h0000_0000_676e_6f6c,  // long
		64'h0000_0074_616f_6c66   // float
	};

	localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
		4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd5, 4'd8, 4'd4, 4'd3, 4'd4, 4'd5
	};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f");
	endfunction

	function automatic logic is_octal(input logic [7:0] c);
		return c >= "0" && c <= "7";
	endfunction

	// Caller has already checked that the length fits in the prefix.
	function automatic logic kw_match(input logic [KW_PREFIX_W-1:0] prefix,
	                                  input logic [KW_LEN_W-1:0] len);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (prefix == KW_TEXT[k] && len == KW_LEN[k])
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/c_subset_lexer_dfa.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_subset_lexer_dfa
// Tokeniser state machine for a C subset, one source byte per transfer.
// ----------------------------------------------------------------------------
// One source byte is taken per clock cycle while ch_stall is low. Each byte
// runs through the lexer state machine, keyword compare and (where a byte
// closes a pending token) a second pass from the begin state in the same
// cycle, and yields zero, one or two tokens. Tokens leave through a
// four-entry result queue, one per cycle while tok_stall is low; the byte
// side stalls while fewer than two queue slots are free, so a run of bytes
// giving two tokens each is paced by the single token output. A token still
// open when input stops is not reported. Row, column and length saturate.
module c_subset_lexer_dfa #(
	parameter int POS_BITS = csl_pkg::POS_BITS_DEF,
	parameter int LEN_BITS = csl_pkg::LEN_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                ch_valid,
	output      logic                ch_stall,
	input  wire logic [7:0]          ch,
	output      logic                tok_valid,
	input  wire logic                tok_stall,
	output      logic [4:0]          token_type,
	output      logic [POS_BITS-1:0] start_row,
	output      logic [POS_BITS-1:0] start_column,
	output      logic [LEN_BITS-1:0] token_length,
	output      logic                last
);
	import csl_pkg::*;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic [4:0]          ttype;
		logic [POS_BITS-1:0] row;
		logic [POS_BITS-1:0] col;
		logic [LEN_BITS-1:0] len;
		logic                last;
	} tok_rec_t;

	function automatic logic [POS_BITS-1:0] sat_pos(input logic [POS_BITS-1:0] v);
		return (v == '1) ? v : v + POS_BITS'(1);
	endfunction

	function automatic logic [LEN_BITS-1:0] sat_len(input logic [LEN_BITS-1:0] v);
		return (v == '1) ? v : v + LEN_BITS'(1);
	endfunction

	function automatic logic [KW_PREFIX_W-1:0] app_prefix(
		input logic [KW_PREFIX_W-1:0] p, input logic [LEN_BITS-1:0] len,
		input logic [7:0] c);
		logic [KW_PREFIX_W-1:0] r;
		r = p;
		if (len < LEN_BITS'(KW_CHARS))
			r[{len[KW_IDX_W-1:0], 3'b000} +: 8] = c;
		return r;
	endfunction

	// lexer state
	lex_state_t             st_q, st_n;
	logic [4:0]             ptype_q, ptype_n;
	logic [POS_BITS-1:0]    trow_q, trow_n, tcol_q, tcol_n;
	logic [LEN_BITS-1:0]    tlen_q, tlen_n;
	logic [KW_PREFIX_W-1:0] pref_q, pref_n;
	logic [POS_BITS-1:0]    row_q, row_n, col_q, col_n;

	// result queue
	tok_rec_t            q_mem_q [QDEPTH];
	logic [QPTR_W-1:0]   head_q, tail_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic [QCNT_W-1:0]   n_push;

	logic                ch_xfer, tok_xfer;
	logic                pe_v, be_v, redo, is_kw;
	logic [4:0]          pe_type, be_type;
	logic [LEN_BITS-1:0] pe_len, len_app;
	logic [KW_PREFIX_W-1:0] pref_app;
	tok_rec_t            rec_a, rec_b;

	assign ch_stall = cnt_q > QCNT_W'(QDEPTH - 2);
	assign ch_xfer  = ch_valid && !ch_stall;
	assign tok_valid = cnt_q != '0;
	assign tok_xfer  = tok_valid && !tok_stall;

	assign len_app  = sat_len(tlen_q);
	assign pref_app = app_prefix(pref_q, tlen_q, ch);
	assign is_kw    = (tlen_q <= LEN_BITS'(KW_CHARS)) && kw_match(pref_q, tlen_q[KW_LEN_W-1:0]);

	always_comb begin
		logic       do_start, single;
		lex_state_t start_st;
		logic [4:0] start_type;

		st_n    = st_q;
		ptype_n = ptype_q;
		trow_n  = trow_q;
		tcol_n  = tcol_q;
		tlen_n  = tlen_q;
		pref_n  = pref_q;
		row_n   = row_q;
		col_n   = sat_pos(col_q);
		pe_v    = 1'b0;
		pe_type = TOK_ERR;
		be_v    = 1'b0;
		be_type = TOK_ERR;
		redo    = 1'b0;
		do_start   = 1'b0;
		single     = 1'b0;
		start_st   = S_BEGIN;
		start_type = TOK_ERR;

		// pending token: extend, close, or close and hand the byte on
		if (st_q != S_BEGIN) begin
			unique case (st_q)
				S_IDENT: begin
					if (is_alpha(ch) || is_digit(ch)) begin
						tlen_n = len_app; pref_n = pref_app;
					end else begin
						pe_v = 1'b1; pe_type = is_kw ? TOK_KW : TOK_ID; redo = 1'b1;
					end
				end
				S_INT, S_OCT, S_HEX: begin
					priority if ((st_q == S_INT && is_digit(ch)) ||
					             (st_q == S_OCT && is_octal(ch)) ||
					             (st_q == S_HEX && is_hex(ch))) begin
						tlen_n = len_app; pref_n = pref_app;
					end else if (st_q == S_INT && ch == ".") begin
						tlen_n = len_app; pref_n = pref_app;
						ptype_n = TOK_FLT; st_n = S_FLOAT;
					end else if (ch == "l" || ch == "L") begin
						tlen_n = len_app; pref_n = pref_app;
						pe_v = 1'b1; pe_type = TOK_LONG;
					end else begin
						pe_v = 1'b1; pe_type = ptype_q; redo = 1'b1;
					end
				end
				S_FLOAT: begin
					if (is_digit(ch)) begin
						tlen_n = len_app; pref_n = pref_app;
					end else begin
						pe_v = 1'b1; pe_type = ptype_q; redo = 1'b1;
					end
				end
				S_ASSIGN, S_LESS, S_GTR, S_NOTEQ: begin
					if (ch == "=") begin
						tlen_n = len_app; pref_n = pref_app; pe_v = 1'b1;
						unique case (st_q)
							S_ASSIGN: pe_type = TOK_EQ;
							S_LESS:   pe_type = TOK_LSEQ;
							S_GTR:    pe_type = TOK_GTEQ;
							default:  pe_type = TOK_NTEQ;
						endcase
					end else begin
						pe_v = 1'b1; redo = 1'b1;
						pe_type = (st_q == S_NOTEQ) ? TOK_ERR : ptype_q;
					end
				end
				S_ZERO: begin
					priority if (is_octal(ch)) begin
						tlen_n = len_app; pref_n = pref_app; st_n = S_OCT;
					end else if (ch == "x" || ch == "X") begin
						tlen_n = len_app; pref_n = pref_app; st_n = S_HEXPRE;
					end else if (ch == "8" || ch == "9") begin
						tlen_n = len_app; pref_n = pref_app;
						pe_v = 1'b1; pe_type = TOK_ERR;
					end else begin
						pe_v = 1'b1; pe_type = TOK_INT; redo = 1'b1;
					end
				end
				S_HEXPRE: begin
					if (is_hex(ch)) begin
						tlen_n = len_app; pref_n = pref_app; st_n = S_HEX;
					end else begin
						pe_v = 1'b1; pe_type = TOK_ERR; redo = 1'b1;
					end
				end
				S_STR: begin
					tlen_n = len_app; pref_n = pref_app;
					if (ch == "\"") begin
						pe_v = 1'b1; pe_type = TOK_STR;
					end
				end
				S_AND, S_OR: begin
					// a lone '&' or '|' swallows the next byte
					if (ch == ((st_q == S_AND) ? "&" : "|")) begin
						tlen_n = len_app; pref_n = pref_app;
						pe_v = 1'b1; pe_type = ptype_q;
					end else begin
						pe_v = 1'b1; pe_type = TOK_ERR;
					end
				end
				S_SQ: begin
					tlen_n = len_app; pref_n = pref_app;
					if (ch == "'") begin
						pe_v = 1'b1; pe_type = TOK_ERR;
					end else begin
						st_n = S_CHAR;
					end
				end
				S_CHAR: begin
					tlen_n = len_app; pref_n = pref_app;
					if (ch == "'") begin
						pe_v = 1'b1; pe_type = TOK_CHR;
					end else begin
						st_n = S_CHARERR;
					end
				end
				S_CHARERR: begin
					tlen_n = len_app; pref_n = pref_app;
					if (ch == "'") begin
						pe_v = 1'b1; pe_type = TOK_ERR;
					end
				end
				default: begin
					st_n = S_BEGIN; redo = 1'b1;
				end
			endcase
			if (pe_v)
				st_n = S_BEGIN;
		end
		pe_len = tlen_n;

		// begin state, also for a byte handed on by a closed token
		if (st_q == S_BEGIN || redo) begin
			priority if (ch == " ") begin
			end else if (ch == "\n") begin
				row_n = sat_pos(row_q);
				col_n = '0;
			end else if (is_alpha(ch)) begin
				do_start = 1'b1; start_type = TOK_ID; start_st = S_IDENT;
			end else if (ch >= "1" && ch <= "9") begin
				do_start = 1'b1; start_type = TOK_INT; start_st = S_INT;
			end else begin
				do_start = 1'b1;
				unique case (ch)
					"=":  begin start_type = TOK_ASSIGN; start_st = S_ASSIGN; end
					"<":  begin start_type = TOK_LS;     start_st = S_LESS;   end
					">":  begin start_type = TOK_GT;     start_st = S_GTR;    end
					"!":  begin start_type = TOK_NTEQ;   start_st = S_NOTEQ;  end
					"0":  begin start_type = TOK_INT;    start_st = S_ZERO;   end
					"'":  begin start_type = TOK_CHR;    start_st = S_SQ;     end
					"\"": begin start_type = TOK_STR;    start_st = S_STR;    end
					"&":  begin start_type = TOK_AND;    start_st = S_AND;    end
					"|":  begin start_type = TOK_OR;     start_st = S_OR;     end
					"+":  begin start_type = TOK_PL;     single = 1'b1; end
					"-":  begin start_type = TOK_MINUS;  single = 1'b1; end
					"*":  begin start_type = TOK_MUL;    single = 1'b1; end
					"/":  begin start_type = TOK_DIV;    single = 1'b1; end
					"(":  begin start_type = TOK_LPAR;   single = 1'b1; end
					")":  begin start_type = TOK_RPAR;   single = 1'b1; end
					"[":  begin start_type = TOK_LBRK;   single = 1'b1; end
					"]":  begin start_type = TOK_RBRK;   single = 1'b1; end
					"{":  begin start_type = TOK_LBRACE; single = 1'b1; end
					"}":  begin start_type = TOK_RBRACE; single = 1'b1; end
					",":  begin start_type = TOK_COMMA;  single = 1'b1; end
					";":  begin start_type = TOK_SEMI;   single = 1'b1; end
					"#":  begin start_type = TOK_SHARP;  single = 1'b1; end
					default: begin start_type = TOK_ERR; single = 1'b1; end
				endcase
			end
			if (do_start) begin
				ptype_n = start_type;
				trow_n  = row_n;
				tcol_n  = col_n;
				tlen_n  = LEN_BITS'(1);
				pref_n  = KW_PREFIX_W'(ch);
				st_n    = single ? S_BEGIN : start_st;
			end
			if (single) begin
				be_v = 1'b1; be_type = start_type;
			end
		end
	end

	// queue records: a closed pending token always goes out first
	always_comb begin
		rec_a.ttype = pe_v ? pe_type : be_type;
		rec_a.row   = pe_v ? trow_q  : trow_n;
		rec_a.col   = pe_v ? tcol_q  : tcol_n;
		rec_a.len   = pe_v ? pe_len  : LEN_BITS'(1);
		rec_a.last  = !(pe_v && be_v);
		rec_b.ttype = be_type;
		rec_b.row   = trow_n;
		rec_b.col   = tcol_n;
		rec_b.len   = LEN_BITS'(1);
		rec_b.last  = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_BEGIN;
			ptype_q <= '0;
			trow_q  <= '0;
			tcol_q  <= '0;
			tlen_q  <= '0;
			pref_q  <= '0;
			row_q   <= POS_BITS'(1);
			col_q   <= '0;
		end else if (ch_xfer) begin
			st_q    <= st_n;
			ptype_q <= ptype_n;
			trow_q  <= trow_n;
			tcol_q  <= tcol_n;
			tlen_q  <= tlen_n;
			pref_q  <= pref_n;
			row_q   <= row_n;
			col_q   <= col_n;
		end
	end

	assign n_push = ch_xfer ? (QCNT_W'(pe_v) + QCNT_W'(be_v)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			tail_q <= tail_q + n_push[QPTR_W-1:0];
			if (tok_xfer)
				head_q <= head_q + QPTR_W'(1);
			cnt_q <= cnt_q + n_push - QCNT_W'(tok_xfer);
		end
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (ch_xfer && (pe_v || be_v))
			q_mem_q[tail_q] <= rec_a;
		if (ch_xfer && pe_v && be_v)
			q_mem_q[tail_q + QPTR_W'(1)] <= rec_b;
	end

	assign token_type   = q_mem_q[head_q].ttype;
	assign start_row    = q_mem_q[head_q].row;
	assign start_column = q_mem_q[head_q].col;
	assign token_length = q_mem_q[head_q].len;
	assign last         = q_mem_q[head_q].last;

endmodule
`default_nettype wire
